### sv/mts_pkg.sv
package mts_pkg;

    localparam int TPM_W   = 16;
    localparam int ENTRY_W = 11;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 9;

    localparam logic [CNT_W-1:0] MAX_NOTES = 9'd256;

    localparam logic [1:0] REG_TPM    = 2'd0;
    localparam logic [1:0] REG_REPEAT = 2'd1;
    localparam logic [1:0] REG_DUTY   = 2'd2;

    localparam logic [15:0] RST_TPM    = 16'd6000;
    localparam logic [3:0]  RST_REPEAT = 4'd5;
    localparam logic [9:0]  RST_DUTY   = 10'd213;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic             done;
        logic [TPM_W-1:0] quo;
    } div_stat_t;

    // note length in ticks from the quarter-note length q
    function automatic logic [LEN_W-1:0] note_len(input logic [TPM_W-1:0] q,
                                                  input logic [2:0] code);
        logic [TPM_W+1:0] q3;
        logic [LEN_W-1:0] len;
        q3 = {2'b00, q} + {1'b0, q, 1'b0};
        case (code)
            3'd0: len = {2'b00, q[15:2]};
            3'd1: len = {1'b0, q3[17:3]};
            3'd2: len = {1'b0, q[15:1]};
            3'd3: len = q3[17:2];
            3'd4: len = q;
            3'd5: len = q3[16:1];
            3'd6: len = {q[14:0], 1'b0};
            3'd7: len = {q[13:0], 2'b00};
            default: len = q;
        endcase
        return len;
    endfunction

endpackage

### sv/melody_tone_sequencer_unit.sv
// A start runs a bit-serial tempo division and a note store read before its result beat.
// One item in flight; next beat taken once the result is registered. Synchronous
// active-low reset clears control, counters, tone outputs and configuration to
// defaults; the note store is not cleared.
module melody_tone_sequencer_unit
    import mts_pkg::*;
#(
    parameter int NOTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_address, pitch_period, length_code, note_count, tempo_bpm
    input  logic [39:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tone_period, pwm_duty, playing, note_position, repeat_position
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW = $clog2(NOTE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(NOTE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV,
        ST_WAIT,
        ST_BEGIN,
        ST_RESP
    } state_t;

    function automatic logic [AW-1:0] depth_mod(input logic [7:0] a);
        logic [11:0] r;
        r = {4'b0000, a};
        for (int k = 3; k >= 0; k--) begin
            if (r >= 12'(NOTE_DEPTH << k)) begin
                r = r - 12'(NOTE_DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    state_t           state_reg;
    logic [15:0]      tpm_reg;
    logic [3:0]       rep_total_reg;
    logic [9:0]       duty_cfg_reg;
    logic [15:0]      q_reg;
    logic [15:0]      ticks_reg;
    logic [AW-1:0]    base_reg;
    logic [AW-1:0]    ptr_reg;
    logic [CNT_W-1:0] len_reg;
    logic [7:0]       cursor_reg;
    logic [3:0]       rep_reg;
    logic             active_reg;
    logic [7:0]       period_reg;
    logic [9:0]       duty_reg;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;

    cmd_t             in_cmd;
    logic [7:0]       in_addr;
    logic [7:0]       in_pitch;
    logic [2:0]       in_code;
    logic [CNT_W-1:0] in_count;
    logic [7:0]       in_tempo;
    logic             s_accept;
    logic [AW-1:0]    in_addr_mod;
    logic             mem_we;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [7:0]       ent_pitch;
    logic [15:0]      ent_len;
    logic [AW:0]      ptr_inc;
    logic [AW-1:0]    ptr_next;
    div_stat_t        div_stat;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_addr  = s_tdata[7:0];
    assign in_pitch = s_tdata[15:8];
    assign in_code  = s_tdata[18:16];
    assign in_count = s_tdata[27:19];
    assign in_tempo = s_tdata[35:28];

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign in_addr_mod = depth_mod(in_addr);
    assign mem_we      = s_accept && (in_cmd == CMD_WRITE);

    mts_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NOTE_DEPTH)
    ) u_note_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (in_addr_mod),
        .wdata ({in_code, in_pitch}),
        .raddr (ptr_reg),
        .rdata (mem_rdata)
    );

    mts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept && (in_cmd == CMD_START)),
        .dividend (tpm_reg),
        .divisor  (in_tempo),
        .stat     (div_stat)
    );

    assign ent_pitch = mem_rdata[7:0];
    assign ent_len   = note_len(q_reg, mem_rdata[10:8]);
    assign ptr_inc   = {1'b0, ptr_reg} + {{AW{1'b0}}, 1'b1};
    assign ptr_next  = (ptr_inc == DEPTH_W) ? '0 : ptr_inc[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg       <= RST_TPM;
            rep_total_reg <= RST_REPEAT;
            duty_cfg_reg  <= RST_DUTY;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TPM:    tpm_reg       <= cfg_wdata;
                REG_REPEAT: rep_total_reg <= cfg_wdata[3:0];
                REG_DUTY:   duty_cfg_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            q_reg        <= '0;
            ticks_reg    <= '0;
            base_reg     <= '0;
            ptr_reg      <= '0;
            len_reg      <= '0;
            cursor_reg   <= '0;
            rep_reg      <= '0;
            active_reg   <= 1'b0;
            period_reg   <= '0;
            duty_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != ST_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (in_cmd)
                            CMD_TICK: begin
                                state_reg <= active_reg ? ST_TICK : ST_RESP;
                            end
                            CMD_START: begin
                                base_reg   <= in_addr_mod;
                                ptr_reg    <= in_addr_mod;
                                len_reg    <= (in_count > MAX_NOTES) ? MAX_NOTES : in_count;
                                cursor_reg <= '0;
                                rep_reg    <= '0;
                                state_reg  <= ST_DIV;
                            end
                            CMD_WRITE: state_reg <= ST_RESP;
                            default:   state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_TICK: begin
                    if (ticks_reg != '0) begin
                        if (ticks_reg == {3'b000, ent_len[15:3]}) begin
                            duty_reg <= '0;
                        end
                        ticks_reg <= ticks_reg - 16'd1;
                        state_reg <= ST_RESP;
                    end else if (({1'b0, cursor_reg} + 9'd1) < len_reg) begin
                        cursor_reg <= cursor_reg + 8'd1;
                        ptr_reg    <= ptr_next;
                        state_reg  <= ST_WAIT;
                    end else if (({1'b0, rep_reg} + 5'd1) < {1'b0, rep_total_reg}) begin
                        rep_reg    <= rep_reg + 4'd1;
                        cursor_reg <= '0;
                        ptr_reg    <= base_reg;
                        state_reg  <= ST_WAIT;
                    end else begin
                        duty_reg   <= '0;
                        active_reg <= 1'b0;
                        state_reg  <= ST_RESP;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        q_reg     <= div_stat.quo;
                        state_reg <= ST_BEGIN;
                    end
                end
                ST_WAIT: state_reg <= ST_BEGIN;
                ST_BEGIN: begin
                    if (ent_pitch == '0) begin
                        duty_reg <= '0;
                    end else begin
                        period_reg <= ent_pitch;
                        duty_reg   <= duty_cfg_reg;
                    end
                    ticks_reg  <= ent_len;
                    active_reg <= 1'b1;
                    state_reg  <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, rep_reg, cursor_reg, active_reg,
                                         duty_reg, period_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside of a start");

    a_duty_needs_active: assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg != '0 |-> active_reg)
        else $error("tone driven while not playing");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, ptr_reg} < DEPTH_W)
        else $error("note pointer beyond store depth");

    a_result_after_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_RESP)
        else $error("result beat not issued from response state");

endmodule

### sv/mts_ram.sv
module mts_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/mts_div.sv
module mts_div
    import mts_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [TPM_W-1:0] dividend,
    input  logic [7:0]       divisor,
    output div_stat_t        stat
);

    logic [4:0]       cnt_reg;
    logic [TPM_W-1:0] dvd_reg;
    logic [7:0]       rem_reg;
    logic [7:0]       dvs_reg;
    logic             done_reg;
    logic [8:0]       rem_shift;
    logic             qbit;
    logic [8:0]       rem_next;

    // restoring division, one quotient bit per cycle; divisor 0 yields all ones
    assign rem_shift = {rem_reg, dvd_reg[TPM_W-1]};
    assign qbit      = (rem_shift >= {1'b0, dvs_reg});
    assign rem_next  = qbit ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && (cnt_reg == 5'd1);
            if (start) begin
                cnt_reg <= 5'(TPM_W);
                dvd_reg <= dividend;
                dvs_reg <= divisor;
                rem_reg <= '0;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - 5'd1;
                dvd_reg  <= {dvd_reg[TPM_W-2:0], qbit};
                rem_reg  <= rem_next[7:0];
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.quo  = dvd_reg;

endmodule

### tb/testbench.sv
module testbench;
    import mts_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] addr;
        logic [7:0] pitch;
        logic [2:0] code;
        logic [8:0] count;
        logic [7:0] tempo;
    } melody_cmd_t;

    // packed from the lowest bit up: tone_period first
    typedef struct packed {
        logic [3:0] repeat_position;
        logic [7:0] note_position;
        logic       playing;
        logic [9:0] pwm_duty;
        logic [7:0] tone_period;
    } tone_state_t;

    class melody_scoreboard;
        logic [15:0] tick_rate;
        logic [3:0]  repeat_limit;
        logic [9:0]  sound_duty;
        logic [10:0] notes [256];
        logic [15:0] len_tab [8];
        logic [15:0] remaining;
        logic [7:0]  base_addr;
        logic [8:0]  melody_len;
        logic [7:0]  cursor;
        logic [3:0]  rep_count;
        logic        active;
        logic [7:0]  period;
        logic [9:0]  duty;
        tone_state_t waiting [$];
        int          mismatches;

        function new();
            tick_rate    = RST_TPM;
            repeat_limit = RST_REPEAT;
            sound_duty   = RST_DUTY;
            foreach (notes[i]) notes[i] = '0;
            foreach (len_tab[i]) len_tab[i] = '0;
            remaining  = '0;
            base_addr  = '0;
            melody_len = '0;
            cursor     = '0;
            rep_count  = '0;
            active     = 1'b0;
            period     = '0;
            duty       = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_TPM:    tick_rate    = val;
                REG_REPEAT: repeat_limit = val[3:0];
                REG_DUTY:   sound_duty   = val[9:0];
                default: ;
            endcase
        endfunction

        function logic [10:0] current_entry();
            logic [7:0] a;
            a = base_addr + cursor;
            return notes[a];
        endfunction

        function void start_note();
            logic [10:0] e;
            e = current_entry();
            if (e[7:0] == 8'd0) begin
                duty = '0;
            end else begin
                period = e[7:0];
                duty   = sound_duty;
            end
            remaining = len_tab[e[10:8]];
            active    = 1'b1;
        endfunction

        function void derive_lengths(logic [7:0] tempo);
            int unsigned q;
            q = (tempo == 8'd0) ? 32'hFFFF : 32'(tick_rate) / 32'(tempo);
            len_tab[0] = 16'(q / 4);
            len_tab[1] = 16'(q * 3 / 8);
            len_tab[2] = 16'(q / 2);
            len_tab[3] = 16'(q * 3 / 4);
            len_tab[4] = 16'(q);
            len_tab[5] = 16'(q * 3 / 2);
            len_tab[6] = 16'(q * 2);
            len_tab[7] = 16'(q * 4);
        endfunction

        function void advance();
            logic [10:0] e;
            if (!active) return;
            if (remaining != 16'd0) begin
                e = current_entry();
                if (remaining == (len_tab[e[10:8]] >> 3)) duty = '0;
                remaining = remaining - 16'd1;
            end else if (32'(cursor) + 1 < 32'(melody_len)) begin
                cursor = cursor + 8'd1;
                start_note();
            end else if (32'(rep_count) + 1 < 32'(repeat_limit)) begin
                rep_count = rep_count + 4'd1;
                cursor    = '0;
                start_note();
            end else begin
                duty   = '0;
                active = 1'b0;
            end
        endfunction

        function void note_beat(melody_cmd_t b);
            tone_state_t r;
            case (b.cmd)
                CMD_TICK: advance();
                CMD_START: begin
                    base_addr  = b.addr;
                    melody_len = (b.count > MAX_NOTES) ? MAX_NOTES : b.count;
                    derive_lengths(b.tempo);
                    cursor    = '0;
                    rep_count = '0;
                    start_note();
                end
                CMD_WRITE: notes[b.addr] = {b.code, b.pitch};
                default: ;
            endcase
            r.tone_period     = period;
            r.pwm_duty        = duty;
            r.playing         = active;
            r.note_position   = cursor;
            r.repeat_position = rep_count;
            waiting.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 50) $display("error at %0t: %s", $time, what);
        endtask

        task check_beat(logic [31:0] data);
            tone_state_t got;
            tone_state_t want;
            got = data[30:0];
            if (waiting.size() == 0) begin
                report("result beat with nothing outstanding");
                return;
            end
            want = waiting.pop_front();
            if (got.tone_period !== want.tone_period)
                report($sformatf("tone_period %0d, want %0d", got.tone_period,
                                 want.tone_period));
            if (got.pwm_duty !== want.pwm_duty)
                report($sformatf("pwm_duty %0d, want %0d", got.pwm_duty, want.pwm_duty));
            if (got.playing !== want.playing)
                report($sformatf("playing %0b, want %0b", got.playing, want.playing));
            if (got.note_position !== want.note_position)
                report($sformatf("note_position %0d, want %0d", got.note_position,
                                 want.note_position));
            if (got.repeat_position !== want.repeat_position)
                report($sformatf("repeat_position %0d, want %0d", got.repeat_position,
                                 want.repeat_position));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    bit calm      = 1'b0;
    bit long_hold = 1'b0;

    melody_scoreboard sb = new();

    melody_tone_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end

    initial begin : result_ready
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (300) @(negedge aclk);
                long_hold = 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge aclk);
            end
        end
    end

    function automatic melody_cmd_t make_item(logic [1:0] c, logic [7:0] a, logic [7:0] p,
                                              logic [2:0] k, logic [8:0] n, logic [7:0] t);
        melody_cmd_t b;
        b.cmd   = c;
        b.addr  = a;
        b.pitch = p;
        b.code  = k;
        b.count = n;
        b.tempo = t;
        return b;
    endfunction

    task automatic offer_beat(melody_cmd_t b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = b.cmd;
        s_tdata  = {4'h0, b.tempo, b.count, b.code, b.pitch, b.addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_beat(b);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle(int extra);
        s_tvalid = 1'b0;
        while (sb.waiting.size() != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic tick_burst(int n);
        repeat (n) offer_beat(make_item(CMD_TICK, 8'($urandom), 8'($urandom), 3'($urandom),
                                        9'($urandom), 8'($urandom)));
    endtask

    // start, then mostly ticks with the odd rewrite or unused command mixed in
    task automatic play_random(int budget);
        int sent;
        int span;
        melody_cmd_t b;
        sent = 0;
        while (sent < budget) begin
            b = make_item(CMD_START, 8'($urandom), 8'($urandom), 3'($urandom), 9'd0, 8'd0);
            case ($urandom_range(0, 19))
                0, 1:    b.count = '0;
                2:       b.count = 9'($urandom_range(256, 511));
                3, 4:    b.count = 9'($urandom_range(5, 24));
                default: b.count = 9'($urandom_range(1, 4));
            endcase
            b.tempo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
            offer_beat(b);
            sent++;
            span = $urandom_range(10, 60);
            repeat (span) begin
                b = make_item(CMD_TICK, 8'($urandom), 8'($urandom), 3'($urandom),
                              9'($urandom), 8'($urandom));
                case ($urandom_range(0, 24))
                    0: b.cmd = CMD_WRITE;
                    1: b.cmd = CMD_UNUSED;
                    default: ;
                endcase
                offer_beat(b);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] tune [8] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd0, 8'd77, 8'd200, 8'd9};
        logic [15:0] tpm;
        logic [3:0]  reps;
        logic [9:0]  level;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        offer_beat(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 3'd7, 9'h1FF, 8'hFF));
        offer_beat(make_item(CMD_TICK, 8'd0, 8'd0, 3'd0, 9'd0, 8'd0));
        for (int i = 0; i < 8; i++)
            offer_beat(make_item(CMD_WRITE, 8'(252 + i), tune[i], 3'(i), 9'd0, 8'd0));
        offer_beat(make_item(CMD_START, 8'd252, 8'd0, 3'd0, 9'd8, 8'd255));
        tick_burst(3);
        offer_beat(make_item(CMD_WRITE, 8'd252, 8'd33, 3'd7, 9'd0, 8'd0));
        tick_burst(1);
        offer_beat(make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 3'($urandom),
                             9'($urandom), 8'($urandom)));
        offer_beat(make_item(CMD_START, 8'd255, 8'd0, 3'd0, 9'd0, 8'd0));
        tick_burst(1);
        offer_beat(make_item(CMD_START, 8'd0, 8'd0, 3'd0, 9'd1, 8'd1));
        tick_burst(1);

        for (int a = 0; a < 256; a++)
            offer_beat(make_item(CMD_WRITE, 8'(a),
                                 ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom),
                                 3'($urandom), 9'($urandom), 8'($urandom)));
        offer_beat(make_item(CMD_START, 8'($urandom), 8'd0, 3'd0, 9'h1FF, 8'd7));
        tick_burst(4);
        offer_beat(make_item(CMD_START, 8'($urandom), 8'd0, 3'd0, 9'd256, 8'd0));
        tick_burst(2);

        for (int p = 0; p < 6; p++) begin
            wait_idle(4);
            case (p)
                0: begin tpm = 16'd1;     reps = 4'd0;  level = 10'd1023; end
                1: begin tpm = 16'hFFFF;  reps = 4'd15; level = 10'd0;    end
                2: begin tpm = 16'd40;    reps = 4'd1;  level = 10'($urandom); end
                3: begin tpm = 16'($urandom_range(8, 255));  reps = 4'd15;
                         level = 10'($urandom); end
                4: begin tpm = 16'($urandom_range(16, 120)); reps = 4'($urandom);
                         level = 10'($urandom); end
                default: begin tpm = 16'($urandom_range(20, 200));
                               reps = 4'($urandom_range(1, 3));
                               level = 10'($urandom); end
            endcase
            write_reg(REG_TPM, tpm);
            write_reg(REG_REPEAT, {12'($urandom), reps});
            write_reg(REG_DUTY, {6'($urandom), level});
            if (p == 2) long_hold = 1'b1;
            if (p == 5) calm = 1'b1;
            play_random(70);
        end

        wait_idle(25);
        if (sb.mismatches == 0) begin
            $display("melody_tone_sequencer_unit: match");
        end else begin
            $display("melody_tone_sequencer_unit: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("melody_tone_sequencer_unit: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/mts_pkg.sv
sv/mts_ram.sv
sv/mts_div.sv
sv/melody_tone_sequencer_unit.sv
tb/testbench.sv
